// ----- rtl/pwmc_pkg.sv -----
package pwmc_pkg;

    // field widths
    localparam int SAMPLE_W          = 32;
    localparam int WEIGHT_W          = 16;
    localparam int PROD_W            = SAMPLE_W + WEIGHT_W;
    localparam int PANEL_DEPTH_DEF   = 64;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [WEIGHT_W-1:0] weight_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // panel sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SUM,
        S_START,
        S_WAIT,
        S_DRAIN
    } pwmc_state_t;

endpackage

// ----- rtl/pwmc_if.sv -----
interface pwmc_in_if;
    import pwmc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    weight_t weight;
    logic    last_in_panel;

    modport source (output valid, output sample, output weight, output last_in_panel,
                    input ready);
    modport sink   (input valid, input sample, input weight, input last_in_panel,
                    output ready);
endinterface

interface pwmc_out_if;
    import pwmc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t centered;
    logic    last_of_run;
    logic    zero_weight;
    logic    overflowed;

    modport source (output valid, output centered, output last_of_run, output zero_weight,
                    output overflowed, input ready);
    modport sink   (input valid, input centered, input last_of_run, input zero_weight,
                    input overflowed, output ready);
endinterface

// ----- rtl/pwmc_buf.sv -----
module pwmc_buf #(
    parameter int DEPTH  = pwmc_pkg::PANEL_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  pwmc_pkg::sample_t     wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output pwmc_pkg::sample_t     rd_data
);
    import pwmc_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pwmc_div.sv -----
module pwmc_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 22
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);
    import pwmc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] mag_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, mag_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        mag_next = {mag_reg[NUM_W-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitude in, quotient bits shift in from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(NUM_W'(-mag_reg)) : $signed(mag_reg);

endmodule

// ----- rtl/panel_weighted_mean_centering_core.sv -----
// channel   dir  payload                                          handshake
// items     in   sample(32,s) weight(16,u) last_in_panel(1)       valid/ready
// results   out  centered(32,s) last_of_run zero_weight overflowed valid/ready
//
// loading takes one word per cycle; samples up to the panel depth go into the panel
// buffer memory, and each weighted product is registered before it is added to the sum.
// closing a panel passes through the sum and start states and, while the shift-subtract
// divider works through every bit of the weighted sum (54 at the default depth), the wait
// state; a zero weight sum skips both. draining goes through a registered buffer read,
// one buffer entry per cycle unless results stalls, ahead of the output register.
// reset clears all control and panel state; the buffer itself needs no clearing.
// a stall on results holds the output register and the pending read; items waits
// only while a panel is being closed or drained.
module panel_weighted_mean_centering_core #(
    parameter int PANEL_DEPTH = pwmc_pkg::PANEL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pwmc_in_if.sink     items,
    pwmc_out_if.source  results
);
    import pwmc_pkg::*;

    localparam int ADDR_W = (PANEL_DEPTH > 1) ? $clog2(PANEL_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PANEL_DEPTH + 1);
    localparam int SUM_W  = PROD_W + $clog2(PANEL_DEPTH);
    localparam int TOT_W  = WEIGHT_W + $clog2(PANEL_DEPTH);

    pwmc_state_t state_reg;
    pwmc_state_t state_next;

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] wsum_reg;
    logic [TOT_W-1:0]        wtot_reg;
    logic                    ovf_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    prod_vld_reg;
    sample_t                 mean_reg;
    logic                    zero_reg;

    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    rd_pend_reg;
    logic                    rd_last_reg;

    logic                    out_vld_reg;
    sample_t                 centered_reg;
    logic                    last_reg;
    logic                    zw_reg;
    logic                    of_reg;

    logic                    in_ready;
    logic                    div_start;
    logic                    in_acc;
    logic                    store;
    logic signed [PROD_W:0]  prod_full;
    logic                    load_out;
    logic                    rd_issue;
    logic                    drain_done;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;
    sample_t                 rd_data;
    logic signed [SAMPLE_W:0] diff;
    sample_t                 sat_val;

    // handshake and item path
    assign in_acc    = items.valid && items.ready;
    assign store     = in_acc && (cnt_reg < CNT_W'(PANEL_DEPTH));
    assign prod_full = $signed({items.sample[SAMPLE_W-1], items.sample})
                     * $signed({1'b0, items.weight});

    // drain pipeline control
    assign load_out   = rd_pend_reg && (!out_vld_reg || results.ready);
    assign rd_issue   = (state_reg == S_DRAIN) && (rd_idx_reg < cnt_reg)
                     && (!rd_pend_reg || load_out);
    assign drain_done = (state_reg == S_DRAIN) && (rd_idx_reg == cnt_reg) && !rd_pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && items.last_in_panel)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = (wtot_reg == '0) ? S_DRAIN : S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            S_LOAD:  in_ready  = 1'b1;
            S_START: div_start = (wtot_reg != '0);
            default:
            begin
                in_ready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    assign items.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // panel accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            wsum_reg     <= '0;
            wtot_reg     <= '0;
            ovf_reg      <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else if (drain_done)
        begin
            cnt_reg      <= '0;
            wsum_reg     <= '0;
            wtot_reg     <= '0;
            ovf_reg      <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= store;
            if (prod_vld_reg)
            begin
                wsum_reg <= wsum_reg
                          + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            if (store)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                wtot_reg <= wtot_reg + TOT_W'(items.weight);
            end
            else if (in_acc)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // product register, one multiply per item
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
    end

    // mean capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            zero_reg <= 1'b0;
        end
        else if (state_reg == S_START)
        begin
            zero_reg <= (wtot_reg == '0);
            mean_reg <= '0;
        end
        else if (div_done)
        begin
            mean_reg <= div_quot[SAMPLE_W-1:0];
        end
    end

    pwmc_div #(
        .NUM_W (SUM_W),
        .DEN_W (TOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (wsum_reg),
        .den   (wtot_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    pwmc_buf #(
        .DEPTH  (PANEL_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (items.sample),
        .rd_en   (rd_issue),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // read sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            if (rd_issue)
            begin
                rd_idx_reg  <= rd_idx_reg + 1'b1;
                rd_pend_reg <= 1'b1;
                rd_last_reg <= (rd_idx_reg == cnt_reg - 1'b1);
            end
            else if (load_out)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (drain_done)
            begin
                rd_idx_reg <= '0;
            end
        end
    end

    // subtract mean and saturate
    always_comb
    begin
        diff = {rd_data[SAMPLE_W-1], rd_data} - {mean_reg[SAMPLE_W-1], mean_reg};
        if (diff[SAMPLE_W] != diff[SAMPLE_W-1])
        begin
            sat_val = diff[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
        end
        else
        begin
            sat_val = diff[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            centered_reg <= sat_val;
            last_reg     <= rd_last_reg;
            zw_reg       <= zero_reg;
            of_reg       <= ovf_reg;
        end
    end

    assign results.valid       = out_vld_reg;
    assign results.centered    = centered_reg;
    assign results.last_of_run = last_reg;
    assign results.zero_weight = zw_reg;
    assign results.overflowed  = of_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PANEL_DEPTH))
        else $error("panel count beyond buffer depth");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    a_pend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_DRAIN))
        else $error("buffer read pending outside drain");

    a_ovf_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !store && !items.last_in_panel) |=> ovf_reg)
        else $error("dropped word did not mark overflow");

endmodule

// ----- sim/panel_mean_checker.sv -----
`timescale 1ns / 100ps

module panel_mean_checker #(
    parameter int PANEL_DEPTH = pwmc_pkg::PANEL_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pwmc_in_if   items,
    pwmc_out_if  results,
    output int   fail_count,
    output int   pending
);
    import pwmc_pkg::*;

    typedef struct {
        sample_t centered;
        logic    last_of_run;
        logic    zero_weight;
        logic    overflowed;
    } centered_word_t;

    // running copy of the panel being loaded
    sample_t        panel_store [PANEL_DEPTH];
    int unsigned    stored;
    longint         weighted_sum;
    int unsigned    weight_total;
    bit             spilled;
    centered_word_t centered_q [$];

    // weighted mean of the panel, then one centered word per stored sample
    task automatic close_panel();
        longint         mean;
        longint         diff;
        centered_word_t word;
        mean = 0;
        if (weight_total != 0)
            mean = weighted_sum / longint'(weight_total);
        for (int k = 0; k < int'(stored); k++)
        begin
            diff = longint'(panel_store[k]) - mean;
            if (diff > longint'(SAMPLE_MAX))
                word.centered = SAMPLE_MAX;
            else if (diff < longint'(SAMPLE_MIN))
                word.centered = SAMPLE_MIN;
            else
                word.centered = sample_t'(diff[SAMPLE_W-1:0]);
            word.last_of_run = (k == int'(stored) - 1);
            word.zero_weight = (weight_total == 0);
            word.overflowed  = spilled;
            centered_q.push_back(word);
        end
        stored       = 0;
        weighted_sum = 0;
        weight_total = 0;
        spilled      = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        centered_word_t want;
        if (!rst_n)
        begin
            stored       = 0;
            weighted_sum = 0;
            weight_total = 0;
            spilled      = 1'b0;
            fail_count   = 0;
            centered_q.delete();
        end
        else
        begin
            // accepted input word: store and accumulate, or drop past the depth
            if (items.valid && items.ready)
            begin
                if (stored < PANEL_DEPTH)
                begin
                    panel_store[stored] = items.sample;
                    stored = stored + 1;
                    weighted_sum = weighted_sum
                                 + longint'(items.sample) * longint'(items.weight);
                    weight_total = weight_total + items.weight;
                end
                else
                    spilled = 1'b1;
                if (items.last_in_panel)
                    close_panel();
            end

            // accepted result word against the oldest prediction
            if (results.valid && results.ready)
            begin
                if (centered_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, centered %0d", $time,
                             results.centered);
                    fail_count++;
                end
                else
                begin
                    want = centered_q.pop_front();
                    if (results.centered !== want.centered)
                    begin
                        $display("%0t: centered mismatch, expected %0d, got %0d", $time,
                                 want.centered, results.centered);
                        fail_count++;
                    end
                    if (results.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run mismatch, expected %0b, got %0b", $time,
                                 want.last_of_run, results.last_of_run);
                        fail_count++;
                    end
                    if (results.zero_weight !== want.zero_weight)
                    begin
                        $display("%0t: zero_weight mismatch, expected %0b, got %0b", $time,
                                 want.zero_weight, results.zero_weight);
                        fail_count++;
                    end
                    if (results.overflowed !== want.overflowed)
                    begin
                        $display("%0t: overflowed mismatch, expected %0b, got %0b", $time,
                                 want.overflowed, results.overflowed);
                        fail_count++;
                    end
                end
            end
        end
        pending = centered_q.size();
    end

endmodule

// ----- sim/panel_weighted_mean_centering_core_tb.sv -----
`timescale 1ns / 100ps

module panel_weighted_mean_centering_core_tb;
    import pwmc_pkg::*;

    localparam int PANEL_DEPTH  = PANEL_DEPTH_DEF;
    localparam int PHASE_ITEMS  = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 300000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sender_idle_pct;
    int   stall_pct;
    int   hold_req;
    int   cycle_count;

    pwmc_in_if  items_ch ();
    pwmc_out_if results_ch ();

    panel_weighted_mean_centering_core #(
        .PANEL_DEPTH(PANEL_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .results(results_ch)
    );

    panel_mean_checker #(
        .PANEL_DEPTH(PANEL_DEPTH)
    ) mean_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, or a long hold-off on request
    initial
    begin
        int hold_len;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_len = hold_req;
                hold_req = 0;
                results_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
                results_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one input word and hold it until accepted
    task automatic send_word(input sample_t s, input weight_t w, input logic last);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        items_ch.valid         <= 1'b1;
        items_ch.sample        <= s;
        items_ch.weight        <= w;
        items_ch.last_in_panel <= last;
        do @(posedge clk); while (!items_ch.ready);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(5))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(200)) - 100);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic weight_t pick_weight();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return weight_t'(16'h8000);
            default: return weight_t'($urandom);
        endcase
    endfunction

    // one panel of random samples, optionally with all weights zero
    task automatic send_panel(input int len, input bit zero_weights);
        for (int i = 0; i < len; i++)
            send_word(pick_sample(), zero_weights ? weight_t'(0) : pick_weight(),
                      i == len - 1);
    endtask

    // mostly short panels, now and then one around the buffer depth
    task automatic send_random_panels(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 3)
                len = $urandom_range(PANEL_DEPTH + 4, PANEL_DEPTH - 2);
            else
                len = $urandom_range(8, 1);
            send_panel(len, $urandom_range(9) == 0);
            sent += len;
        end
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic wait_results_flushed();
        items_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_req        = 0;
        rst_n                  <= 1'b0;
        items_ch.valid         <= 1'b0;
        items_ch.sample        <= '0;
        items_ch.weight        <= '0;
        items_ch.last_in_panel <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single word panel at full scale: centers to zero
        send_word(SAMPLE_MAX, '1, 1'b1);
        // mean near the minimum, so the maximum saturates high
        send_word(SAMPLE_MIN, '1, 1'b0);
        send_word(SAMPLE_MAX, weight_t'(1), 1'b1);
        // mean near the maximum, so the minimum saturates low
        send_word(SAMPLE_MAX, '1, 1'b0);
        send_word(SAMPLE_MIN, weight_t'(1), 1'b1);
        // zero weight sum: mean taken as zero, samples pass through
        send_word(SAMPLE_MIN, '0, 1'b0);
        send_word(sample_t'(-7), '0, 1'b0);
        send_word(SAMPLE_MAX, '0, 1'b1);
        send_word(sample_t'(12345), '0, 1'b1);
        // negative mean truncates toward zero (-10 / 3 gives -3)
        send_word(sample_t'(-5), weight_t'(2), 1'b0);
        send_word(sample_t'(0), weight_t'(1), 1'b1);
        // mixed signs with half-scale weights
        send_word(sample_t'(32'h0001_0000), weight_t'(16'h8000), 1'b0);
        send_word(sample_t'(32'hFFFE_0000), weight_t'(16'h4000), 1'b0);
        send_word(sample_t'(32'h5555_AAAA), weight_t'(16'h7FFF), 1'b1);
        wait_results_flushed();

        // no idling
        send_random_panels(PHASE_ITEMS);
        wait_results_flushed();

        // sender idle
        sender_idle_pct = 50;
        send_random_panels(PHASE_ITEMS);
        wait_results_flushed();

        // receiver stalling
        sender_idle_pct = 0;
        stall_pct       = 50;
        send_random_panels(PHASE_ITEMS);
        wait_results_flushed();

        // both sides
        sender_idle_pct = 34;
        stall_pct       = 34;
        send_random_panels(PHASE_ITEMS);
        wait_results_flushed();

        // long receiver hold-off while full and overfull panels keep coming
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_req        = HOLD_CYCLES;
        send_panel(PANEL_DEPTH, 1'b0);
        send_panel(PANEL_DEPTH + 3, 1'b0);
        send_random_panels(20);
        wait_results_flushed();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
